>>> rtl/arxk_pkg.sv
`default_nettype none
package arxk_pkg;

    typedef enum logic [1:0] {
        REQ_KEY   = 2'd0,
        REQ_GEN   = 2'd1,
        REQ_INTEG = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KEY_MOD,
        ST_KEY_RD,
        ST_LOAD,
        ST_FIRST,
        ST_ITER,
        ST_FINAL,
        ST_GEN_OUT,
        ST_INT_MOD,
        ST_INT_RD,
        ST_OUT
    } state_t;

    // request into the residue unit
    typedef struct packed {
        logic start;
        logic one_byte;
    } mod_req_t;

    localparam logic [63:0] RESET_WORD = 64'h5555_5555_5555_5555;
    localparam logic [63:0] GEN_SALT   = 64'hDEAD_BEEF_CAFE_BABE;
    localparam logic [5:0]  CROSS_ROT  = 6'd31;
    localparam logic [5:0]  HASH_ROT   = 6'd7;
    localparam int          FOLD_SHIFT = 32;
    localparam logic [3:0]  MOD_STEPS  = 4'd8;

    function automatic logic [63:0] rotl64(input logic [63:0] x, input logic [5:0] r);
        logic [127:0] dbl;
        dbl = {x, x} << r;
        return dbl[127:64];
    endfunction

endpackage
`default_nettype wire

>>> rtl/arx_keystream_generator_unit.sv
`default_nettype none
// Input transfer to m_tvalid: generate runs load, first, one iteration per word, final,
// gen-out and out; key runs key-mod and key-read, then the same pass and out; integrity
// runs int-mod, int-read and out; unused kinds go straight to out. One item at a time; the
// pass walks the ring through one dual-port RAM and one shared add-rotate-xor unit per word.
// Reset (aresetn low, synchronous): every word reads as 0x5555... through per-word
// valid bits, the hash clears to zero, no result is pending. No clearing pass.
module arx_keystream_generator_unit #(
    parameter int STATE_WORDS = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [7:0] key_char, [13:8] key_index, [77:14] position, [85:78] data_byte
    input  wire logic [87:0] s_tdata,
    // [1:0] req_type
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] stream_byte, [71:8] integrity_hash
    output logic [71:0]      m_tdata
);

    localparam int AW = $clog2(STATE_WORDS);
    localparam logic [AW:0]   NWORDS = (AW + 1)'(STATE_WORDS);
    localparam logic [AW-1:0] LAST_I = AW'(STATE_WORDS - 1);

    arxk_pkg::state_t state_reg, state_next;
    arxk_pkg::req_t   kind_reg, kind_next;

    logic [AW-1:0]          iter_reg, iter_next;
    logic [63:0]            carry_reg, carry_next;
    logic [63:0]            mixv_reg, mixv_next;
    logic [7:0]             char_reg, char_next;
    logic [2:0]             lane_reg, lane_next;
    logic [7:0]             byte_reg, byte_next;
    logic [7:0]             stream_reg, stream_next;
    logic [63:0]            hash_reg, hash_next;
    logic [7:0]             out_byte_reg, out_byte_next;
    logic [63:0]            out_hash_reg, out_hash_next;
    logic                   out_valid_reg, out_valid_next;
    logic [STATE_WORDS-1:0] valid_reg, valid_next;
    logic                   rd_valid_reg;

    // word RAM
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [63:0]   ram_wdata, ram_rdata, rd_word;

    // residue unit
    arxk_pkg::mod_req_t mod_req;
    logic [63:0]        mod_operand;
    logic               mod_done;
    logic [AW-1:0]      mod_res;

    // mixing step
    logic [5:0]  rot_amt;
    logic [63:0] arx_new, arx_carry;

    logic [AW:0]   ahead;
    logic [63:0]   key_mask, gen_word, hash_rot;
    logic          in_xfer;

    arxk_ram #(
        .WIDTH (64),
        .DEPTH (STATE_WORDS)
    ) u_words (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    arxk_mod_unit #(
        .MODULUS (STATE_WORDS)
    ) u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mod_req),
        .operand (mod_operand),
        .done    (mod_done),
        .residue (mod_res)
    );

    arxk_arx_unit u_arx (
        .cur_word   (carry_reg),
        .mix_val    (mixv_reg),
        .next_word  (rd_word),
        .rot_amt    (rot_amt),
        .new_word   (arx_new),
        .carry_word (arx_carry)
    );

    // a word never written since reset reads as the reset pattern
    assign rd_word  = rd_valid_reg ? ram_rdata : arxk_pkg::RESET_WORD;
    assign s_tready = (state_reg == arxk_pkg::ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign rot_amt  = 6'(iter_reg) + 6'd1;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_hash_reg, out_byte_reg};

    always_comb begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        iter_next      = iter_reg;
        carry_next     = carry_reg;
        mixv_next      = mixv_reg;
        char_next      = char_reg;
        lane_next      = lane_reg;
        byte_next      = byte_reg;
        stream_next    = stream_reg;
        hash_next      = hash_reg;
        out_byte_next  = out_byte_reg;
        out_hash_next  = out_hash_reg;
        out_valid_next = out_valid_reg && !m_tready;
        valid_next     = valid_reg;

        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = carry_reg;
        ram_raddr   = '0;
        mod_req     = '{start: 1'b0, one_byte: 1'b0};
        mod_operand = s_tdata[77:14];

        ahead    = (AW + 1)'(iter_reg) + (AW + 1)'(2);
        key_mask = {{56{char_reg[7]}}, char_reg} << {lane_reg, 3'b000};
        gen_word = (mod_res == '0) ? carry_reg : rd_word;
        hash_rot = arxk_pkg::rotl64(hash_reg, arxk_pkg::HASH_ROT) ^ {56'd0, byte_reg};

        unique case (state_reg)
            arxk_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    kind_next   = arxk_pkg::req_t'(s_tuser);
                    char_next   = s_tdata[7:0];
                    lane_next   = s_tdata[10:8];
                    byte_next   = s_tdata[85:78];
                    stream_next = '0;
                    mixv_next   = s_tdata[77:14] ^ arxk_pkg::GEN_SALT;
                    unique case (arxk_pkg::req_t'(s_tuser))
                        arxk_pkg::REQ_KEY: begin
                            mod_req     = '{start: 1'b1, one_byte: 1'b1};
                            mod_operand = {58'd0, s_tdata[13:8]};
                            state_next  = arxk_pkg::ST_KEY_MOD;
                        end
                        arxk_pkg::REQ_GEN: begin
                            mod_req    = '{start: 1'b1, one_byte: 1'b0};
                            state_next = arxk_pkg::ST_LOAD;
                        end
                        arxk_pkg::REQ_INTEG: begin
                            mod_req     = '{start: 1'b1, one_byte: 1'b1};
                            mod_operand = {56'd0, s_tdata[85:78]};
                            state_next  = arxk_pkg::ST_INT_MOD;
                        end
                        default: begin
                            state_next = arxk_pkg::ST_OUT;
                        end
                    endcase
                end
            end
            arxk_pkg::ST_KEY_MOD: begin
                ram_raddr = mod_res;
                if (mod_done) begin
                    state_next = arxk_pkg::ST_KEY_RD;
                end
            end
            arxk_pkg::ST_KEY_RD: begin
                // xor the key character in; that word is also the mix value
                ram_we     = 1'b1;
                ram_waddr  = mod_res;
                ram_wdata  = rd_word ^ key_mask;
                mixv_next  = rd_word ^ key_mask;
                valid_next[mod_res] = 1'b1;
                state_next = arxk_pkg::ST_LOAD;
            end
            arxk_pkg::ST_LOAD: begin
                ram_raddr  = '0;
                state_next = arxk_pkg::ST_FIRST;
            end
            arxk_pkg::ST_FIRST: begin
                carry_next = rd_word;
                ram_raddr  = AW'(1);
                iter_next  = '0;
                state_next = arxk_pkg::ST_ITER;
            end
            arxk_pkg::ST_ITER: begin
                // write word i, carry the disturbed next word, prefetch two ahead
                ram_we     = 1'b1;
                ram_waddr  = iter_reg;
                ram_wdata  = arx_new;
                valid_next[iter_reg] = 1'b1;
                carry_next = arx_carry;
                ram_raddr  = (ahead >= NWORDS) ? AW'(ahead - NWORDS) : AW'(ahead);
                iter_next  = iter_reg + AW'(1);
                if (iter_reg == LAST_I) begin
                    state_next = arxk_pkg::ST_FINAL;
                end
            end
            arxk_pkg::ST_FINAL: begin
                // the last step disturbs word 0 once more
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = carry_reg;
                ram_raddr = mod_res;
                if (mod_done) begin
                    state_next = (kind_reg == arxk_pkg::REQ_GEN) ? arxk_pkg::ST_GEN_OUT
                                                                 : arxk_pkg::ST_OUT;
                end
            end
            arxk_pkg::ST_GEN_OUT: begin
                // word 0 comes from the carry: the RAM read collided with its write
                stream_next = gen_word[7:0] ^ gen_word[arxk_pkg::FOLD_SHIFT +: 8];
                state_next  = arxk_pkg::ST_OUT;
            end
            arxk_pkg::ST_INT_MOD: begin
                ram_raddr = mod_res;
                if (mod_done) begin
                    state_next = arxk_pkg::ST_INT_RD;
                end
            end
            arxk_pkg::ST_INT_RD: begin
                hash_next  = hash_rot + rd_word;
                state_next = arxk_pkg::ST_OUT;
            end
            arxk_pkg::ST_OUT: begin
                // hold until the output register is free
                if (!out_valid_reg || m_tready) begin
                    out_byte_next  = stream_reg;
                    out_hash_next  = hash_reg;
                    out_valid_next = 1'b1;
                    state_next     = arxk_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = arxk_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= arxk_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
            hash_reg      <= '0;
            rd_valid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            valid_reg     <= valid_next;
            hash_reg      <= hash_next;
            rd_valid_reg  <= valid_reg[ram_raddr];
        end
        kind_reg     <= kind_next;
        iter_reg     <= iter_next;
        carry_reg    <= carry_next;
        mixv_reg     <= mixv_next;
        char_reg     <= char_next;
        lane_reg     <= lane_next;
        byte_reg     <= byte_next;
        stream_reg   <= stream_next;
        out_byte_reg <= out_byte_next;
        out_hash_reg <= out_hash_next;
    end

endmodule
`default_nettype wire

>>> rtl/arxk_ram.sv
`default_nettype none
module arxk_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> rtl/arxk_mod_unit.sv
`default_nettype none
// Residue of a 64-bit operand, or of its low byte alone, by MODULUS, one byte per cycle, MSB first.
module arxk_mod_unit #(
    parameter int MODULUS = 8,
    localparam int RW = $clog2(MODULUS)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire arxk_pkg::mod_req_t req,
    input  wire logic [63:0]       operand,
    output logic                   done,
    output logic [RW-1:0]          residue
);

    localparam int SHIFT = 24;
    localparam int TW    = RW + 8;
    localparam int PW    = TW + SHIFT;
    localparam int RECIP = (1 << SHIFT) / MODULUS;

    logic [63:0]   opnd_reg, opnd_next;
    logic [3:0]    cnt_reg, cnt_next;
    logic [RW-1:0] rem_reg, rem_next;

    logic [TW-1:0] t, q, qn, diff, red;
    logic [PW-1:0] prod;

    // reciprocal estimate is low by at most one: one subtract corrects it
    always_comb begin
        t    = {rem_reg, opnd_reg[63:56]};
        prod = PW'(t) * PW'(RECIP);
        q    = TW'(prod >> SHIFT);
        qn   = TW'(q * TW'(MODULUS));
        diff = t - qn;
        red  = (diff >= TW'(MODULUS)) ? diff - TW'(MODULUS) : diff;
    end

    always_comb begin
        opnd_next = opnd_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        if (req.start) begin
            rem_next = '0;
            if (req.one_byte) begin
                opnd_next = {operand[7:0], 56'd0};
                cnt_next  = 4'd1;
            end else begin
                opnd_next = operand;
                cnt_next  = arxk_pkg::MOD_STEPS;
            end
        end else if (cnt_reg != 4'd0) begin
            rem_next  = RW'(red);
            opnd_next = {opnd_reg[55:0], 8'd0};
            cnt_next  = cnt_reg - 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        opnd_reg <= opnd_next;
        rem_reg  <= rem_next;
    end

    assign done    = (cnt_reg == 4'd0);
    assign residue = rem_reg;

endmodule
`default_nettype wire

>>> rtl/arxk_arx_unit.sv
`default_nettype none
// One add-rotate-xor step of the mixing pass.
module arxk_arx_unit (
    input  wire logic [63:0] cur_word,
    input  wire logic [63:0] mix_val,
    input  wire logic [63:0] next_word,
    input  wire logic [5:0]  rot_amt,
    output logic      [63:0] new_word,
    output logic      [63:0] carry_word
);

    logic [63:0] sum;

    always_comb begin
        sum        = cur_word + mix_val;
        new_word   = arxk_pkg::rotl64(sum, rot_amt) ^ next_word;
        carry_word = next_word ^ arxk_pkg::rotl64(new_word, arxk_pkg::CROSS_ROT);
    end

endmodule
`default_nettype wire

>>> tb/arx_keystream_generator_unit_test.sv
`default_nettype none
module arx_keystream_generator_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import arxk_pkg::*;

    localparam int          RING_WORDS    = 8;
    localparam logic [63:0] RING_INIT     = 64'h5555_5555_5555_5555;
    localparam logic [63:0] POSITION_SALT = 64'hDEAD_BEEF_CAFE_BABE;
    localparam int          MAX_GAP       = 18;
    localparam int          RANDOM_ITEMS  = 2000;
    // Slowest transfer: sender gap + key latency + receiver stall, far below this.
    // The long receiver hold-off must also stay below it.
    localparam int          STALL_LIMIT   = 3000;
    localparam int          HOLD_OFF      = 300;
    // Key items take longest; drain comfortably past one.
    localparam int          DRAIN_CYCLES  = 4 * (RING_WORDS + 8);

    typedef struct packed {
        logic [7:0]  stream_byte;
        logic [63:0] integrity_hash;
    } keystream_result_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    wire logic   s_tready;
    // [7:0] key_char, [13:8] key_index, [77:14] position, [85:78] data_byte
    logic [87:0] s_tdata  = '0;
    // [1:0] req_type
    logic [1:0]  s_tuser  = REQ_NONE;
    wire logic   m_tvalid;
    logic        m_tready = 1'b0;
    // [7:0] stream_byte, [71:8] integrity_hash
    wire logic [71:0] m_tdata;

    // Predicted copy of the word ring and the running hash.
    logic [63:0] ring_words [RING_WORDS];
    logic [63:0] running_hash;

    keystream_result_t pending_keystream[$];

    int  error_count    = 0;
    int  items_accepted = 0;
    int  idle_cycles    = 0;
    int  rx_hold_cycles = 0;
    bit  tx_idle_en     = 1'b1;
    bit  rx_idle_en     = 1'b1;

    arx_keystream_generator_unit #(
        .STATE_WORDS(RING_WORDS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [63:0] rotate_left(input logic [63:0] x, input int amount);
        int r;
        r = amount & 63;
        if (r == 0) begin
            return x;
        end
        return (x << r) | (x >> (64 - r));
    endfunction

    function automatic void clear_ring();
        for (int i = 0; i < RING_WORDS; i++) begin
            ring_words[i] = RING_INIT;
        end
        running_hash = '0;
    endfunction

    // One sequential add-rotate-xor sweep over the ring; each word feeds the next.
    function automatic void stir_ring(input logic [63:0] mix);
        int          nx;
        logic [63:0] w;
        for (int i = 0; i < RING_WORDS; i++) begin
            nx = (i + 1) % RING_WORDS;
            w = ring_words[i] + mix;
            w = rotate_left(w, (i + 1) % 63);
            w ^= ring_words[nx];
            ring_words[i] = w;
            ring_words[nx] ^= rotate_left(w, 31);
        end
    endfunction

    function automatic keystream_result_t next_keystream(
        input req_t        kind,
        input logic [7:0]  key_char,
        input logic [5:0]  key_index,
        input logic [63:0] position,
        input logic [7:0]  data_byte
    );
        keystream_result_t r;
        logic [63:0]       ch;
        logic [63:0]       w;
        int                wi;
        r.stream_byte = '0;
        case (kind)
            REQ_KEY: begin
                ch = {{56{key_char[7]}}, key_char};
                wi = key_index % RING_WORDS;
                ring_words[wi] ^= ch << (8 * key_index[2:0]);
                stir_ring(ring_words[wi]);
            end
            REQ_GEN: begin
                stir_ring(position ^ POSITION_SALT);
                w = ring_words[position % RING_WORDS];
                r.stream_byte = w[7:0] ^ w[39:32];
            end
            REQ_INTEG: begin
                running_hash = rotate_left(running_hash, 7) ^ {56'd0, data_byte};
                running_hash += ring_words[data_byte % RING_WORDS];
            end
            default: begin
                // unused kind: state untouched
            end
        endcase
        r.integrity_hash = running_hash;
        return r;
    endfunction

    // ------------------------------------------------------------------ checking

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    always @(posedge aclk) begin : check_keystream
        keystream_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_keystream.size() == 0) begin
                report_mismatch("result with nothing pending", m_tdata[71:8], '0);
            end else begin
                want = pending_keystream.pop_front();
                if (m_tdata[7:0] !== want.stream_byte) begin
                    report_mismatch("stream_byte", {56'd0, m_tdata[7:0]},
                                    {56'd0, want.stream_byte});
                end
                if (m_tdata[71:8] !== want.integrity_hash) begin
                    report_mismatch("integrity_hash", m_tdata[71:8], want.integrity_hash);
                end
            end
        end
    end

    // Count cycles with no transfer on either side; a hung block ends the run.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("[%0t] no transfer for %0d cycles", $realtime, STALL_LIMIT);
            $display("** arx_keystream_generator_unit: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------ receiver

    // Draw a stall before each result; a requested hold-off overrides the draw.
    initial begin : result_sink
        int gap;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = rx_idle_en ? $urandom_range(0, MAX_GAP) : 0;
            if (rx_hold_cycles > 0) begin
                gap = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // -------------------------------------------------------------------- sender

    task automatic send_request(
        input req_t        kind,
        input logic [7:0]  key_char,
        input logic [5:0]  key_index,
        input logic [63:0] position,
        input logic [7:0]  data_byte
    );
        int gap;
        gap = tx_idle_en ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {2'b00, data_byte, position, key_index, key_char};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_keystream.push_back(
            next_keystream(kind, key_char, key_index, position, data_byte));
        if (kind != REQ_NONE) begin
            items_accepted++;
        end
    endtask

    function automatic logic [63:0] random_word();
        return {$urandom, $urandom};
    endfunction

    // ----------------------------------------------------------------- tests

    task automatic test_key_extremes();
        send_request(REQ_KEY, 8'h80, 6'd0,  random_word(), 8'($urandom));
        send_request(REQ_KEY, 8'h7F, 6'd7,  random_word(), 8'($urandom));
        send_request(REQ_KEY, 8'h00, 6'd1,  random_word(), 8'($urandom));
        send_request(REQ_KEY, 8'hFF, 6'd8,  random_word(), 8'($urandom));
        // index past the ring wraps onto word index mod ring size
        send_request(REQ_KEY, 8'hA5, 6'd63, random_word(), 8'($urandom));
        send_request(REQ_KEY, 8'h41, 6'd15, random_word(), 8'($urandom));
    endtask

    task automatic test_generate_extremes();
        send_request(REQ_GEN, 8'($urandom), 6'($urandom), 64'd0,                 8'($urandom));
        send_request(REQ_GEN, 8'($urandom), 6'($urandom), '1,                    8'($urandom));
        send_request(REQ_GEN, 8'($urandom), 6'($urandom), 64'd7,                 8'($urandom));
        send_request(REQ_GEN, 8'($urandom), 6'($urandom), 64'h8000_0000_0000_0000,
                     8'($urandom));
        // salt xor gives zero mix value
        send_request(REQ_GEN, 8'($urandom), 6'($urandom), POSITION_SALT,         8'($urandom));
    endtask

    task automatic test_integrity_extremes();
        send_request(REQ_INTEG, 8'($urandom), 6'($urandom), random_word(), 8'h00);
        send_request(REQ_INTEG, 8'($urandom), 6'($urandom), random_word(), 8'hFF);
        send_request(REQ_INTEG, 8'($urandom), 6'($urandom), random_word(), 8'h80);
        send_request(REQ_INTEG, 8'($urandom), 6'($urandom), random_word(), 8'h07);
    endtask

    task automatic test_unused_kind();
        send_request(REQ_NONE, 8'($urandom), 6'($urandom), random_word(), 8'($urandom));
        send_request(REQ_INTEG, 8'($urandom), 6'($urandom), random_word(), 8'h5A);
        send_request(REQ_NONE, 8'hFF, 6'd63, '1, 8'hFF);
        send_request(REQ_GEN, 8'($urandom), 6'($urandom), 64'd3, 8'($urandom));
    endtask

    // Mostly well-formed sessions: a key absorbed in order, then a run of
    // consecutive positions with integrity updates mixed in; some noise between.
    task automatic test_random_sessions();
        int          mode;
        int          key_len;
        int          run_len;
        logic [63:0] pos;
        logic [7:0]  ch;
        while (items_accepted < RANDOM_ITEMS) begin
            mode = $urandom_range(0, 3);
            tx_idle_en = mode[0];
            rx_idle_en = mode[1];
            key_len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 63)
                                                  : $urandom_range(1, 16);
            for (int i = 0; i < key_len; i++) begin
                ch = $urandom_range(0, 1) ? 8'($urandom_range(32, 126)) : 8'($urandom);
                send_request(REQ_KEY, ch, 6'(i), random_word(), 8'($urandom));
            end
            pos = $urandom_range(0, 1) ? 64'($urandom_range(0, 1000)) : random_word();
            run_len = $urandom_range(1, 40);
            for (int i = 0; i < run_len; i++) begin
                send_request(REQ_GEN, 8'($urandom), 6'($urandom), pos, 8'($urandom));
                if ($urandom_range(0, 1) == 1) begin
                    send_request(REQ_INTEG, 8'($urandom), 6'($urandom), random_word(),
                                 8'($urandom));
                end
                pos++;
            end
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 12)) begin
                    send_request(req_t'($urandom_range(0, 3)), 8'($urandom),
                                 6'($urandom), random_word(), 8'($urandom));
                end
            end
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // Hold the result side off while the sender keeps offering back to back,
    // so the block fills and stalls its input.
    task automatic test_back_pressure();
        tx_idle_en = 1'b0;
        rx_hold_cycles = HOLD_OFF;
        repeat (20) begin
            send_request(req_t'($urandom_range(0, 2)), 8'($urandom), 6'($urandom),
                         random_word(), 8'($urandom));
        end
        tx_idle_en = 1'b1;
    endtask

    // ------------------------------------------------------------------- main

    initial begin
        clear_ring();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_key_extremes();
        test_generate_extremes();
        test_integrity_extremes();
        test_unused_kind();
        test_back_pressure();
        test_random_sessions();

        s_tvalid <= 1'b0;
        while (pending_keystream.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (pending_keystream.size() != 0) begin
            report_mismatch("results never delivered", 64'(pending_keystream.size()), '0);
        end
        if (error_count == 0) begin
            $display("** arx_keystream_generator_unit: PASSED **");
        end else begin
            $display("** arx_keystream_generator_unit: FAILED **");
        end
        $finish;
    end

endmodule
`default_nettype wire
